// ===== hdl/pcj_pkg.sv =====
package pcj_pkg;

   // saturation quotient is capped at 2^QUO_BITS; with a positive saturation factor the cap clamps to 1.0
   localparam int QUO_BITS = 28;
   localparam int FACTOR_FRAC = 12;
   localparam int SAT_FRAC = 16;
   localparam int HUE_BITS = 21;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int CHAN_BITS = 2;

   localparam logic signed [15:0] UNIT_FACTOR = 16'sd4096;
   localparam logic [CHAN_BITS-1:0] CHAN_RGB = 2'd3;
   localparam logic [CHAN_BITS-1:0] CHAN_TWO = 2'd2;
   localparam logic [16:0] SAT_ONE = 17'd65536;
   localparam logic signed [HUE_BITS-1:0] HUE_SEXTANT = 21'sd65536;
   localparam logic signed [HUE_BITS-1:0] HUE_TURN = 21'sd393216;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BRIGHT   = 3'd0,
      CSR_CONTRAST = 3'd1,
      CSR_SAT      = 3'd2,
      CSR_HUE      = 3'd3,
      CSR_CHAN     = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      BASE_RED   = 2'd0,
      BASE_GREEN = 2'd1,
      BASE_BLUE  = 2'd2
   } hue_base_type;

endpackage

// ===== hdl/pcj_div.sv =====
module pcj_div #(
   parameter int NUM_W = 37,
   parameter int DEN_W = 20,
   parameter int QUO_W = 28
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   // restoring division, one quotient bit per stage; num < den * 2^QUO_W
   localparam int CMP_W = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int BIT = QUO_W - 1 - j;
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [CMP_W-1:0] trial;
      logic             fits;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign trial = CMP_W'(den_prev) << BIT;
      assign fits = CMP_W'(rem_prev) >= trial;

      always_ff @(posedge clock) begin
         quo_ff[j] <= quo_prev | (fits ? (QUO_W'(1) << BIT) : '0);
      end

      if (j < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[j] <= fits ? (rem_prev - trial[NUM_W-1:0]) : rem_prev;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// ===== hdl/pixel_color_jitter.sv =====
// Throughput: one pixel per cycle, no bubbles; busy stays low.
// Depth is set mostly by the two 28-stage restoring dividers (saturation and hue).
// The receiver cannot stall: each result stands on rsp_* for exactly one cycle.
// Reset clears all valid bits and loads the default configuration.
module pixel_color_jitter
   import pcj_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [PIXEL_BITS-1:0]    req_red_in,
   input  logic [PIXEL_BITS-1:0]    req_green_in,
   input  logic [PIXEL_BITS-1:0]    req_blue_in,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output logic                     rsp_valid,
   output logic [PIXEL_BITS-1:0]    rsp_red_out,
   output logic [PIXEL_BITS-1:0]    rsp_green_out,
   output logic [PIXEL_BITS-1:0]    rsp_blue_out
);

   localparam int W = PIXEL_BITS + 4;
   localparam int BP_W = PIXEL_BITS + 17;
   localparam int CP_W = W + 18;
   localparam int NUM_W = W + 17;
   localparam int SP_W = QUO_BITS + 18;
   localparam int VLD_N = 14 + QUO_BITS;
   localparam int POST_N = 6;

   localparam logic signed [W+1:0] ONE_D = $signed({{(W+2-PIXEL_BITS){1'b0}},
                                                    {PIXEL_BITS{1'b1}}});
   localparam logic signed [CP_W-1:0] SAT_HI_X = $signed({{(CP_W-W+1){1'b0}},
                                                         {(W-1){1'b1}}});
   localparam logic signed [CP_W-1:0] SAT_LO_X = $signed({{(CP_W-W+1){1'b1}},
                                                         {(W-1){1'b0}}});
   localparam logic signed [BP_W-1:0] RND_B = $signed({{(BP_W-12){1'b0}}, 1'b1, 11'b0});
   localparam logic signed [CP_W-1:0] RND_C = $signed({{(CP_W-PIXEL_BITS-13){1'b0}}, 1'b1,
                                                      {(PIXEL_BITS+12){1'b0}}});
   localparam logic signed [CP_W-1:0] RND_16 = $signed({{(CP_W-16){1'b0}}, 1'b1, 15'b0});
   localparam logic signed [SP_W-1:0] RND_S = $signed({{(SP_W-12){1'b0}}, 1'b1, 11'b0});

   typedef struct packed {
      logic                  bypass;
      logic [2:0][W-1:0]     y;
      logic [W-1:0]          v;
      logic                  neg;
      hue_base_type          base;
      logic                  s_sat;
      logic                  hzero;
   } side_type;

   typedef struct packed {
      logic              bypass;
      logic [2:0][W-1:0] y;
      logic [W-1:0]      v;
   } post_type;

   function automatic logic signed [W-1:0] sat_mid(input logic signed [CP_W-1:0] a);
      logic signed [W-1:0] r;
      if (a < SAT_LO_X) begin
         r = SAT_LO_X[W-1:0];
      end else if (a > SAT_HI_X) begin
         r = SAT_HI_X[W-1:0];
      end else begin
         r = a[W-1:0];
      end
      return r;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] clamp_pix(input logic signed [W+1:0] a);
      logic [PIXEL_BITS-1:0] r;
      if (a[W+1]) begin
         r = '0;
      end else if (a > ONE_D) begin
         r = '1;
      end else begin
         r = a[PIXEL_BITS-1:0];
      end
      return r;
   endfunction

   // configuration
   logic signed [15:0]    bf_ff, cf_ff, sf_ff, hq_ff;
   logic [CHAN_BITS-1:0]  chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_ff <= UNIT_FACTOR;
         cf_ff <= UNIT_FACTOR;
         sf_ff <= UNIT_FACTOR;
         hq_ff <= '0;
         chan_ff <= CHAN_RGB;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BRIGHT:   bf_ff <= $signed(csr_wdata);
            CSR_CONTRAST: cf_ff <= $signed(csr_wdata);
            CSR_SAT:      sf_ff <= $signed(csr_wdata);
            CSR_HUE:      hq_ff <= $signed(csr_wdata);
            CSR_CHAN:     chan_ff <= csr_wdata[CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // valid bits travel alongside every stage
   logic [VLD_N-1:0] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VLD_N-2:0], start & ~busy};
      end
   end

   // stage 1 .. 7: brightness, contrast, max/min, divider operands
   logic [PIXEL_BITS-1:0]    s1_ch_ff [3];
   logic signed [BP_W-1:0]   s2_prod_ff [3];
   logic signed [W-1:0]      s3_y_ff [3];
   logic signed [CP_W-1:0]   s4_prod_ff [3];
   logic signed [W-1:0]      s5_y_ff [3];
   logic                     s5_bypass_ff;
   logic signed [W-1:0]      s6_mx_ff, s6_mn_ff;
   logic signed [W:0]        s6_diff_ff;
   hue_base_type             s6_base_ff;
   logic signed [W-1:0]      s6_y_ff [3];
   logic                     s6_bypass_ff;
   logic [NUM_W-1:0]         div_ns_ff, div_nh_ff;
   logic [W-1:0]             div_ds_ff, div_dh_ff;
   side_type                 s7_side_ff;

   logic signed [BP_W-1:0]   s3_rnd [3];
   logic signed [W-1:0]      s3_y_in [3];
   logic signed [W+1:0]      s4_d [3];
   logic signed [CP_W-1:0]   s5_rnd [3];
   logic signed [W-1:0]      s5_y_in [3];
   logic signed [W-1:0]      mx, mn;
   logic signed [W:0]        diff;
   hue_base_type             base;
   logic signed [W:0]        delta_s, abs_diff;
   logic [W-1:0]             delta;
   logic                     mx_pos;
   logic [NUM_W-1:0]         ns_in, nh_in;
   logic [W-1:0]             ds_in, dh_in;
   logic                     s_sat_in;
   side_type                 s7_side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_rnd[i] = s2_prod_ff[i] + RND_B;
         s3_y_in[i] = sat_mid(CP_W'(s3_rnd[i] >>> FACTOR_FRAC));
         s4_d[i] = $signed({s3_y_ff[i][W-1], s3_y_ff[i], 1'b0}) - ONE_D;
         s5_rnd[i] = s4_prod_ff[i] + RND_C;
         s5_y_in[i] = sat_mid(s5_rnd[i] >>> (FACTOR_FRAC + 1));
      end
   end

   // max and min; on ties red wins over green, green over blue
   always_comb begin
      mx = s5_y_ff[0];
      mn = s5_y_ff[0];
      if (s5_y_ff[1] > mx) mx = s5_y_ff[1];
      if (s5_y_ff[2] > mx) mx = s5_y_ff[2];
      if (s5_y_ff[1] < mn) mn = s5_y_ff[1];
      if (s5_y_ff[2] < mn) mn = s5_y_ff[2];
      priority if (mx == s5_y_ff[0]) begin
         diff = {s5_y_ff[1][W-1], s5_y_ff[1]} - {s5_y_ff[2][W-1], s5_y_ff[2]};
         base = BASE_RED;
      end else if (mx == s5_y_ff[1]) begin
         diff = {s5_y_ff[2][W-1], s5_y_ff[2]} - {s5_y_ff[0][W-1], s5_y_ff[0]};
         base = BASE_GREEN;
      end else begin
         diff = {s5_y_ff[0][W-1], s5_y_ff[0]} - {s5_y_ff[1][W-1], s5_y_ff[1]};
         base = BASE_BLUE;
      end
   end

   // divider operands; gray or non-positive max divide by one
   always_comb begin
      delta_s = {s6_mx_ff[W-1], s6_mx_ff} - {s6_mn_ff[W-1], s6_mn_ff};
      delta = delta_s[W-1:0];
      abs_diff = s6_diff_ff[W] ? -s6_diff_ff : s6_diff_ff;
      mx_pos = ~s6_mx_ff[W-1] && (s6_mx_ff != '0);
      ns_in = mx_pos ? ({1'b0, delta, {SAT_FRAC{1'b0}}} + NUM_W'(s6_mx_ff[W-1:1])) : '0;
      ds_in = mx_pos ? s6_mx_ff[W-1:0] : W'(1);
      s_sat_in = (W+QUO_BITS)'(ns_in) >= {ds_in, {QUO_BITS{1'b0}}};
      nh_in = {1'b0, abs_diff[W-1:0], {SAT_FRAC{1'b0}}} + NUM_W'(delta[W-1:1]);
      dh_in = (delta == '0) ? W'(1) : delta;
      s7_side_in.bypass = s6_bypass_ff;
      for (int i = 0; i < 3; i++) begin
         s7_side_in.y[i] = s6_y_ff[i];
      end
      s7_side_in.v = s6_mx_ff;
      s7_side_in.neg = s6_diff_ff[W];
      s7_side_in.base = s6_base_ff;
      s7_side_in.s_sat = s_sat_in;
      s7_side_in.hzero = (delta == '0);
   end

   always_ff @(posedge clock) begin
      s1_ch_ff[0] <= req_red_in;
      s1_ch_ff[1] <= (chan_ff >= CHAN_TWO) ? req_green_in : req_red_in;
      s1_ch_ff[2] <= (chan_ff == CHAN_RGB) ? req_blue_in : req_red_in;
      for (int i = 0; i < 3; i++) begin
         s2_prod_ff[i] <= $signed({1'b0, s1_ch_ff[i]}) * bf_ff;
         s3_y_ff[i] <= s3_y_in[i];
         s4_prod_ff[i] <= s4_d[i] * cf_ff;
         s5_y_ff[i] <= s5_y_in[i];
         s6_y_ff[i] <= s5_y_ff[i];
      end
      s5_bypass_ff <= !(chan_ff == CHAN_RGB && (sf_ff != UNIT_FACTOR || hq_ff != '0));
      s6_mx_ff <= mx;
      s6_mn_ff <= mn;
      s6_diff_ff <= diff;
      s6_base_ff <= base;
      s6_bypass_ff <= s5_bypass_ff;
      div_ns_ff <= ns_in;
      div_ds_ff <= ds_in;
      div_nh_ff <= nh_in;
      div_dh_ff <= dh_in;
      s7_side_ff <= s7_side_in;
   end

   // dividers and the matching side line
   logic [QUO_BITS-1:0] quo_s, quo_h;
   side_type            side_ff [QUO_BITS];

   pcj_div #(.NUM_W(NUM_W), .DEN_W(W), .QUO_W(QUO_BITS)) u_div_sat (
      .clock (clock),
      .num   (div_ns_ff),
      .den   (div_ds_ff),
      .quo   (quo_s)
   );

   pcj_div #(.NUM_W(NUM_W), .DEN_W(W), .QUO_W(QUO_BITS)) u_div_hue (
      .clock (clock),
      .num   (div_nh_ff),
      .den   (div_dh_ff),
      .quo   (quo_h)
   );

   always_ff @(posedge clock) begin
      side_ff[0] <= s7_side_ff;
      for (int k = 1; k < QUO_BITS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // post divider: saturation scale, hue wrap, HSV back to RGB, or the bypassed pixel
   side_type                    side_end;
   post_type                    post_ff [POST_N];
   logic signed [SP_W-1:0]      p1_prod_s_ff;
   logic signed [HUE_BITS-1:0]  p1_h_ff;
   logic [16:0]                 p2_s_ff;
   logic [18:0]                 p2_h_ff;
   logic signed [CP_W-1:0]      p3_prod_c_ff;
   logic [2:0]                  p3_sector_ff, p4_sector_ff, p5_sector_ff, p6_sector_ff;
   logic [16:0]                 p3_t_ff, p4_t_ff;
   logic signed [W-1:0]         p4_c_ff, p5_c_ff, p6_c_ff;
   logic signed [W:0]           p4_m_ff, p5_m_ff, p6_m_ff;
   logic signed [CP_W-1:0]      p5_prod_x_ff;
   logic signed [W-1:0]         p6_x_ff;
   logic [PIXEL_BITS-1:0]       rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic [QUO_BITS:0]           sv;
   logic signed [HUE_BITS-1:0]  hq12, h_mag, h1_in, h2_sum;
   logic [18:0]                 h2_in;
   logic signed [SP_W-1:0]      s_rnd;
   logic [16:0]                 s2_in;
   logic [15:0]                 frac;
   logic [16:0]                 t_in;
   logic signed [CP_W-1:0]      c_rnd, x_rnd;
   logic signed [W-1:0]         c_in, x_in;
   logic signed [W:0]           m_in;
   logic signed [W+1:0]         cm, xm, mm;
   logic signed [W+1:0]         r_hsv, g_hsv, b_hsv;
   logic [PIXEL_BITS-1:0]       r_fin, g_fin, b_fin;

   assign side_end = side_ff[QUO_BITS-1];

   always_comb begin
      sv = side_end.s_sat ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, quo_s};
      h_mag = $signed({{(HUE_BITS-17){1'b0}}, quo_h[16:0]});
      h1_in = side_end.neg ? -h_mag : h_mag;
      unique case (side_end.base)
         BASE_GREEN: h1_in = h1_in + (HUE_SEXTANT <<< 1);
         BASE_BLUE:  h1_in = h1_in + (HUE_SEXTANT <<< 2);
         default:    ;
      endcase
      if (h1_in < 0) h1_in = h1_in + HUE_TURN;
      if (side_end.hzero) h1_in = '0;

      // saturation round and clamp to [0, 1]
      s_rnd = (p1_prod_s_ff + RND_S) >>> FACTOR_FRAC;
      if (s_rnd[SP_W-1]) begin
         s2_in = '0;
      end else if (s_rnd > $signed({{(SP_W-17){1'b0}}, SAT_ONE})) begin
         s2_in = SAT_ONE;
      end else begin
         s2_in = s_rnd[16:0];
      end
      // hue shift: one turn is six sextants, so a Q0.15 turn adds twelve times itself
      hq12 = (HUE_BITS'(hq_ff) <<< 3) + (HUE_BITS'(hq_ff) <<< 2);
      h2_sum = p1_h_ff + hq12;
      if (h2_sum < 0) begin
         h2_sum = h2_sum + HUE_TURN;
      end else if (h2_sum >= HUE_TURN) begin
         h2_sum = h2_sum - HUE_TURN;
      end
      h2_in = h2_sum[18:0];

      frac = p2_h_ff[15:0];
      t_in = p2_h_ff[16] ? (SAT_ONE - {1'b0, frac}) : {1'b0, frac};

      c_rnd = (p3_prod_c_ff + RND_16) >>> SAT_FRAC;
      c_in = c_rnd[W-1:0];
      m_in = $signed({post_ff[2].v[W-1], post_ff[2].v}) - {c_in[W-1], c_in};

      x_rnd = (p5_prod_x_ff + RND_16) >>> SAT_FRAC;
      x_in = x_rnd[W-1:0];

      mm = {p6_m_ff[W], p6_m_ff};
      cm = {{2{p6_c_ff[W-1]}}, p6_c_ff} + mm;
      xm = {{2{p6_x_ff[W-1]}}, p6_x_ff} + mm;
      unique case (p6_sector_ff)
         3'd0:    begin r_hsv = cm; g_hsv = xm; b_hsv = mm; end
         3'd1:    begin r_hsv = xm; g_hsv = cm; b_hsv = mm; end
         3'd2:    begin r_hsv = mm; g_hsv = cm; b_hsv = xm; end
         3'd3:    begin r_hsv = mm; g_hsv = xm; b_hsv = cm; end
         3'd4:    begin r_hsv = xm; g_hsv = mm; b_hsv = cm; end
         default: begin r_hsv = cm; g_hsv = mm; b_hsv = xm; end
      endcase
      if (post_ff[POST_N-1].bypass) begin
         r_fin = clamp_pix($signed(post_ff[POST_N-1].y[0]));
         g_fin = clamp_pix($signed(post_ff[POST_N-1].y[1]));
         b_fin = clamp_pix($signed(post_ff[POST_N-1].y[2]));
      end else begin
         r_fin = clamp_pix(r_hsv);
         g_fin = clamp_pix(g_hsv);
         b_fin = clamp_pix(b_hsv);
      end
   end

   always_ff @(posedge clock) begin
      post_ff[0].bypass <= side_end.bypass;
      post_ff[0].y <= side_end.y;
      post_ff[0].v <= side_end.v;
      for (int k = 1; k < POST_N; k++) begin
         post_ff[k] <= post_ff[k-1];
      end
      p1_prod_s_ff <= $signed({1'b0, sv}) * sf_ff;
      p1_h_ff <= h1_in;
      p2_s_ff <= s2_in;
      p2_h_ff <= h2_in;
      p3_prod_c_ff <= $signed(post_ff[1].v) * $signed({1'b0, p2_s_ff});
      p3_sector_ff <= p2_h_ff[18:16];
      p3_t_ff <= t_in;
      p4_c_ff <= c_in;
      p4_m_ff <= m_in;
      p4_sector_ff <= p3_sector_ff;
      p4_t_ff <= p3_t_ff;
      p5_prod_x_ff <= p4_c_ff * $signed({1'b0, p4_t_ff});
      p5_c_ff <= p4_c_ff;
      p5_m_ff <= p4_m_ff;
      p5_sector_ff <= p4_sector_ff;
      p6_x_ff <= x_in;
      p6_c_ff <= p5_c_ff;
      p6_m_ff <= p5_m_ff;
      p6_sector_ff <= p5_sector_ff;
      rsp_red_ff <= r_fin;
      rsp_green_ff <= g_fin;
      rsp_blue_ff <= b_fin;
   end

   assign rsp_valid = vld_ff[VLD_N-1];
   assign rsp_red_out = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out = rsp_blue_ff;

   // hue quotient never exceeds one sextant when an item leaves the divider
   a_hue_quo: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6 + QUO_BITS] |-> quo_h <= QUO_BITS'(SAT_ONE))
      else $error("hue quotient above one sextant");

   // wrapped hue stays inside one turn
   a_hue_wrap: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8 + QUO_BITS] |-> p2_h_ff < 19'(HUE_TURN))
      else $error("hue not wrapped");

   // a result transfer only follows an accepted pixel
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start & ~busy, VLD_N))
      else $error("result without a pixel");

endmodule

// ===== test/testbench.sv =====
module testbench
   import pcj_pkg::*;
();

   localparam int PIX = 16;
   localparam longint ONE = 65535;
   localparam longint MID_HI = (64'sd1 <<< (PIX + 3)) - 1;
   localparam longint MID_LO = -(64'sd1 <<< (PIX + 3));
   localparam longint S1 = 65536;
   localparam longint TURN = 6 * 65536;
   localparam int LATENCY = 41;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [PIX-1:0] req_red_in = '0;
   logic [PIX-1:0] req_green_in = '0;
   logic [PIX-1:0] req_blue_in = '0;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic [PIX-1:0] rsp_red_out, rsp_green_out, rsp_blue_out;

   pixel_color_jitter #(.PIXEL_BITS(PIX)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the configuration
   logic signed [15:0] bright_q = 16'sd4096;
   logic signed [15:0] contrast_q = 16'sd4096;
   logic signed [15:0] sat_q = 16'sd4096;
   logic signed [15:0] hue_q = 16'sd0;
   logic [1:0] chan_q = CHAN_RGB;

   pixel_type expected_pixels[$];
   int mismatches = 0;

   function automatic longint round_shift(longint a, int s);
      return (a + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint div_away(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint mid_sat(longint x);
      return x < MID_LO ? MID_LO : (x > MID_HI ? MID_HI : x);
   endfunction

   function automatic pixel_type jitter_pixel(pixel_type p);
      longint ch[3];
      longint mx, mn, delta, v, s, h, c, x, m, t, f, sector;
      longint r, g, b;
      pixel_type o;
      ch[0] = p.red;
      ch[1] = chan_q >= CHAN_TWO ? longint'(p.green) : ch[0];
      ch[2] = chan_q >= CHAN_RGB ? longint'(p.blue) : ch[0];
      for (int i = 0; i < 3; i++) begin
         x = mid_sat(round_shift(ch[i] * longint'(bright_q), FACTOR_FRAC));
         x = mid_sat(round_shift((2 * x - ONE) * longint'(contrast_q) + ONE * 4096, 13));
         ch[i] = x;
      end
      if (chan_q == CHAN_RGB && (sat_q != UNIT_FACTOR || hue_q != 0)) begin
         r = ch[0]; g = ch[1]; b = ch[2];
         mx = r; mn = r; h = 0;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         delta = mx - mn;
         v = mx;
         s = mx > 0 ? div_away(delta * S1, mx) : 0;
         if (delta > 0) begin
            if (mx == r) h = div_away((g - b) * S1, delta);
            else if (mx == g) h = div_away((b - r) * S1, delta) + 2 * S1;
            else h = div_away((r - g) * S1, delta) + 4 * S1;
            if (h < 0) h += TURN;
         end
         s = round_shift(s * longint'(sat_q), FACTOR_FRAC);
         if (s > S1) s = S1;
         if (s < 0) s = 0;
         h += longint'(hue_q) * 12;
         h %= TURN;
         if (h < 0) h += TURN;
         c = round_shift(v * s, SAT_FRAC);
         sector = h / S1;
         f = h % S1;
         t = sector[0] ? S1 - f : f;
         x = round_shift(c * t, SAT_FRAC);
         m = v - c;
         case (sector)
            0: begin r = c + m; g = x + m; b = m; end
            1: begin r = x + m; g = c + m; b = m; end
            2: begin r = m; g = c + m; b = x + m; end
            3: begin r = m; g = x + m; b = c + m; end
            4: begin r = x + m; g = m; b = c + m; end
            default: begin r = c + m; g = m; b = x + m; end
         endcase
         ch[0] = mid_sat(r); ch[1] = mid_sat(g); ch[2] = mid_sat(b);
      end
      for (int i = 0; i < 3; i++)
         ch[i] = ch[i] < 0 ? 0 : (ch[i] > ONE ? ONE : ch[i]);
      o.red = ch[0][15:0];
      o.green = ch[1][15:0];
      o.blue = ch[2][15:0];
      return o;
   endfunction

   // compare each transfer against the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel %h %h %h",
               rsp_red_out, rsp_green_out, rsp_blue_out);
         end else begin
            want = expected_pixels.pop_front();
            if (want.red !== rsp_red_out || want.green !== rsp_green_out ||
                  want.blue !== rsp_blue_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                     want.red, want.green, want.blue,
                     rsp_red_out, rsp_green_out, rsp_blue_out);
            end
         end
      end
   end

   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, bit gaps);
      pixel_type p;
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      // drop start while idling; hold it when the next transfer follows at once
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p = '{r, g, b};
      start <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_pixels.push_back(jitter_pixel(p));
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BRIGHT: bright_q = data;
         CSR_CONTRAST: contrast_q = data;
         CSR_SAT: sat_q = data;
         CSR_HUE: hue_q = data;
         CSR_CHAN: chan_q = data[1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] bf, logic [15:0] cf, logic [15:0] sf,
         logic [15:0] hq, logic [1:0] ch);
      drain_pipeline();
      write_reg(CSR_BRIGHT, bf);
      write_reg(CSR_CONTRAST, cf);
      write_reg(CSR_SAT, sf);
      write_reg(CSR_HUE, hq);
      write_reg(CSR_CHAN, {14'd0, ch});
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] rand_factor();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h1000;
         3: return 16'($urandom_range(0, 8192));
         4: return 16'(-$urandom_range(0, 4096));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      // extremes, gray, ties, each max channel, under default and jittered settings
      logic [15:0] vals[12][3] = '{
         '{16'h0000, 16'h0000, 16'h0000}, '{16'hffff, 16'hffff, 16'hffff},
         '{16'h8000, 16'h8000, 16'h8000}, '{16'hffff, 16'h0000, 16'h0000},
         '{16'h0000, 16'hffff, 16'h0000}, '{16'h0000, 16'h0000, 16'hffff},
         '{16'hffff, 16'hffff, 16'h0000}, '{16'h0000, 16'hffff, 16'hffff},
         '{16'hffff, 16'h0000, 16'hffff}, '{16'h1234, 16'h8000, 16'h4321},
         '{16'h4000, 16'h2000, 16'h9000}, '{16'h9000, 16'h2000, 16'h4000}};
      for (int i = 0; i < 12; i++) send_pixel(vals[i][0], vals[i][1], vals[i][2], 1'b0);
      set_config(16'h1000, 16'h1000, 16'h1800, 16'h1555, CHAN_RGB);
      for (int i = 0; i < 12; i++) send_pixel(vals[i][0], vals[i][1], vals[i][2], 1'b0);
   endtask

   task automatic test_extreme_factors();
      set_config(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, CHAN_RGB);
      repeat (30) send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1);
      set_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, CHAN_RGB);
      repeat (30) send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1);
      set_config(16'h1000, 16'h1000, 16'h0000, 16'h0000, CHAN_RGB);
      repeat (30) send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1);
   endtask

   task automatic test_channel_counts();
      logic [1:0] counts[4] = '{2'd0, 2'd1, CHAN_TWO, CHAN_RGB};
      foreach (counts[i]) begin
         set_config(rand_factor(), rand_factor(), rand_factor(), 16'($urandom()), counts[i]);
         repeat (40) send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1);
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 20; phase++) begin
         set_config(rand_factor(), rand_factor(),
            $urandom_range(0, 3) == 0 ? 16'h1000 : rand_factor(),
            $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom()),
            $urandom_range(0, 5) == 0 ? 2'($urandom_range(0, 2)) : CHAN_RGB);
         // alternate back-to-back bursts with gapped traffic
         repeat (50) send_pixel(rand_sample(), rand_sample(), rand_sample(),
            phase % 3 != 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extreme_factors();
      test_channel_counts();
      test_random();
      drain_pipeline();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== pixel_color_jitter.f =====
hdl/pcj_pkg.sv
hdl/pcj_div.sv
hdl/pixel_color_jitter.sv
test/testbench.sv
